/* rtl/bspe_pkg.sv */
// bspe_pkg: shared types and constants of the bezier surface point evaluator
// no dependencies
package bspe_pkg;

  localparam int unsigned STORE_DEPTH = 64;
  localparam int unsigned STORE_AW    = 6;
  localparam int unsigned CFG_W       = 4;
  localparam int unsigned CFG_IDX_W   = 1;

  localparam logic [CFG_IDX_W-1:0] REG_ROW_LENGTH = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT  = 1'b1;

  localparam logic [CFG_W-1:0] ROW_LENGTH_RST = 4'd4;
  localparam logic [CFG_W-1:0] ROW_COUNT_RST  = 4'd4;

  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_EVAL  = 1'b1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOAD,
    S_RED,
    S_DONE
  } state_e;

endpackage

/* rtl/bspe_in_if.sv */
// bspe_in_if: input channel of the evaluator, valid/ready plus item fields
// depends on nothing
interface bspe_in_if #(
  parameter int unsigned COORD_BITS      = 32,
  parameter int unsigned PARAM_FRAC_BITS = 16
);
  logic                        valid;
  logic                        ready;
  logic                        func;
  logic [5:0]                  point_index;
  logic signed [COORD_BITS-1:0] coord_x;
  logic signed [COORD_BITS-1:0] coord_y;
  logic signed [COORD_BITS-1:0] coord_z;
  logic [PARAM_FRAC_BITS:0]    u_param;
  logic [PARAM_FRAC_BITS:0]    v_param;

  modport source (output valid, func, point_index, coord_x, coord_y, coord_z,
                  u_param, v_param, input ready);
  modport sink   (input valid, func, point_index, coord_x, coord_y, coord_z,
                  u_param, v_param, output ready);
endinterface

/* rtl/bspe_out_if.sv */
// bspe_out_if: result channel of the evaluator, valid/ready plus surface point
// depends on nothing
interface bspe_out_if #(
  parameter int unsigned COORD_BITS = 32
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] surf_x;
  logic signed [COORD_BITS-1:0] surf_y;
  logic signed [COORD_BITS-1:0] surf_z;

  modport source (output valid, surf_x, surf_y, surf_z, input ready);
  modport sink   (input valid, surf_x, surf_y, surf_z, output ready);
endinterface

/* rtl/bspe_lerp3.sv */
// bspe_lerp3: three-coordinate lerp p + floor((q - p) * t / 2^F)
// no package dependencies
module bspe_lerp3 #(
  parameter int unsigned COORD_BITS      = 32,
  parameter int unsigned PARAM_FRAC_BITS = 16
) (
  input  logic [3*COORD_BITS-1:0]  p_i,
  input  logic [3*COORD_BITS-1:0]  q_i,
  input  logic [PARAM_FRAC_BITS:0] t_i,
  output logic [3*COORD_BITS-1:0]  r_o
);
  localparam int unsigned C  = COORD_BITS;
  localparam int unsigned PW = C + PARAM_FRAC_BITS + 3;

  for (genvar k = 0; k < 3; k++) begin : g_coord
    logic signed [C-1:0]  p, q;
    logic signed [C:0]    d;
    logic signed [PW-1:0] prod;
    logic signed [PW-1:0] sh;

    always_comb begin
      p    = p_i[k*C +: C];
      q    = q_i[k*C +: C];
      d    = (C+1)'(q) - (C+1)'(p);
      prod = PW'(d) * PW'(signed'({1'b0, t_i}));
      sh   = prod >>> PARAM_FRAC_BITS;
      // result is convex so it fits, low bits suffice
      r_o[k*C +: C] = p_i[k*C +: C] + sh[C-1:0];
    end
  end
endmodule

/* rtl/bezier_surface_point_eval_top.sv */
// bezier_surface_point_eval_top: tensor-product bezier surface evaluator
// depends on bspe_pkg, bspe_in_if, bspe_out_if, bspe_lerp3
// write beat: written into the store on accept. evaluate: each row is loaded from the store
// and reduced at v, then the row results are loaded and reduced at u (single lerp unit)
// the result then moves into the output register, which waits while the output stalls
// reset: rst_ni async low idles the sequencer, row_length and row_count reset to 4
module bezier_surface_point_eval_top #(
  parameter int unsigned MAX_ROW_LEN     = 8,
  parameter int unsigned MAX_ROWS        = 8,
  parameter int unsigned COORD_BITS      = 32,
  parameter int unsigned PARAM_FRAC_BITS = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [bspe_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [bspe_pkg::CFG_W-1:0]     cfg_data_i,
  bspe_in_if.sink                        in_i,
  bspe_out_if.source                     out_o
);
  localparam int unsigned LINE = (MAX_ROW_LEN > MAX_ROWS) ? MAX_ROW_LEN : MAX_ROWS;
  localparam int unsigned LW   = $clog2(LINE + 1);
  localparam int unsigned RW   = $clog2(MAX_ROWS);
  localparam int unsigned VW   = 3 * COORD_BITS;
  localparam int unsigned TW   = PARAM_FRAC_BITS + 1;
  localparam int unsigned AW   = bspe_pkg::STORE_AW;
  localparam logic [TW-1:0] T_ONE = TW'(1) << PARAM_FRAC_BITS;

  // configuration registers
  logic [bspe_pkg::CFG_W-1:0] row_len_q, row_cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_len_q <= bspe_pkg::ROW_LENGTH_RST;
      row_cnt_q <= bspe_pkg::ROW_COUNT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        bspe_pkg::REG_ROW_LENGTH: row_len_q <= cfg_data_i;
        bspe_pkg::REG_ROW_COUNT:  row_cnt_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // zero acts as one, oversize clamps to MAX_ROW_LEN or MAX_ROWS
  logic [LW-1:0] n_clamp, m_clamp;
  always_comb begin
    if (row_len_q == '0)                n_clamp = LW'(1);
    else if (int'(row_len_q) > MAX_ROW_LEN) n_clamp = LW'(MAX_ROW_LEN);
    else                                n_clamp = LW'(row_len_q);
    if (row_cnt_q == '0)                m_clamp = LW'(1);
    else if (int'(row_cnt_q) > MAX_ROWS) m_clamp = LW'(MAX_ROWS);
    else                                m_clamp = LW'(row_cnt_q);
  end

  // sequencer state
  bspe_pkg::state_e state_q, state_d;
  logic             uph_q;          // u pass in progress
  logic [LW-1:0]    n_q, m_q;
  logic [RW-1:0]    row_q;
  logic [AW-1:0]    base_q;
  logic [LW-1:0]    iss_q, fill_q, len_q, step_q;
  logic             rdv_q;
  logic [TW-1:0]    u_q, v_q;
  logic             out_valid_q;
  logic [VW-1:0]    out_q;

  logic [VW-1:0]    line_q [LINE];
  logic [VW-1:0]    lerp_r;

  logic in_acc, eval_acc, wr_acc, out_free;
  logic [LW-1:0] cnt;
  logic issue, load_done, red_last, row_last;

  assign in_acc    = in_i.valid && in_i.ready;
  assign eval_acc  = in_acc && (in_i.func == bspe_pkg::FUNC_EVAL);
  assign wr_acc    = in_acc && (in_i.func == bspe_pkg::FUNC_WRITE);
  assign out_free  = !out_valid_q || out_o.ready;
  assign cnt       = uph_q ? m_q : n_q;
  assign issue     = (state_q == bspe_pkg::S_LOAD) && (iss_q < cnt);
  assign load_done = rdv_q && (fill_q == cnt - LW'(1));
  assign red_last  = (state_q == bspe_pkg::S_RED) && (len_q == LW'(1));
  assign row_last  = (LW'(row_q) == m_q - LW'(1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= bspe_pkg::S_IDLE;
    else         state_q <= state_d;
  end

  always_comb begin
    state_d    = state_q;
    in_i.ready = 1'b0;
    unique case (state_q)
      bspe_pkg::S_IDLE: begin
        in_i.ready = 1'b1;
        if (eval_acc) state_d = bspe_pkg::S_LOAD;
      end
      bspe_pkg::S_LOAD: begin
        if (load_done) state_d = bspe_pkg::S_RED;
      end
      bspe_pkg::S_RED: begin
        if (len_q == LW'(1)) state_d = uph_q ? bspe_pkg::S_DONE : bspe_pkg::S_LOAD;
      end
      bspe_pkg::S_DONE: begin
        if (out_free) state_d = bspe_pkg::S_IDLE;
      end
      default: state_d = bspe_pkg::S_IDLE;
    endcase
  end

  // control point store, registered read
  logic [VW-1:0] store_mem [bspe_pkg::STORE_DEPTH];
  logic [VW-1:0] st_rdata_q;
  logic [AW-1:0] st_raddr;
  assign st_raddr = base_q + AW'(iss_q);

  always_ff @(posedge clk_i) begin
    if (wr_acc) begin
      store_mem[in_i.point_index] <= {in_i.coord_z, in_i.coord_y, in_i.coord_x};
    end
    st_rdata_q <= store_mem[st_raddr];
  end

  // per-row reduction results
  logic [VW-1:0] row_mem [MAX_ROWS];
  logic [VW-1:0] rm_rdata_q;

  always_ff @(posedge clk_i) begin
    if (red_last && !uph_q) row_mem[row_q] <= line_q[0];
    rm_rdata_q <= row_mem[iss_q[RW-1:0]];
  end

  bspe_lerp3 #(
    .COORD_BITS      (COORD_BITS),
    .PARAM_FRAC_BITS (PARAM_FRAC_BITS)
  ) u_lerp (
    .p_i (line_q[0]),
    .q_i (line_q[1]),
    .t_i (uph_q ? u_q : v_q),
    .r_o (lerp_r)
  );

  // sequencer counters and flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      uph_q  <= 1'b0;
      n_q    <= '0;
      m_q    <= '0;
      row_q  <= '0;
      base_q <= '0;
      iss_q  <= '0;
      fill_q <= '0;
      len_q  <= '0;
      step_q <= '0;
      rdv_q  <= 1'b0;
      u_q    <= '0;
      v_q    <= '0;
    end else begin
      rdv_q <= issue;
      if (issue) iss_q <= iss_q + LW'(1);
      if (rdv_q) fill_q <= fill_q + LW'(1);
      if (eval_acc) begin
        uph_q  <= 1'b0;
        n_q    <= n_clamp;
        m_q    <= m_clamp;
        row_q  <= '0;
        base_q <= '0;
        iss_q  <= '0;
        fill_q <= '0;
        // parameter above one reads as zero
        u_q    <= (in_i.u_param > T_ONE) ? '0 : in_i.u_param;
        v_q    <= (in_i.v_param > T_ONE) ? '0 : in_i.v_param;
      end
      if (load_done) begin
        len_q  <= cnt;
        step_q <= '0;
      end
      if (state_q == bspe_pkg::S_RED && len_q != LW'(1)) begin
        if (step_q == len_q - LW'(1)) begin
          // drop the stale head, level shrinks by one
          len_q  <= len_q - LW'(1);
          step_q <= '0;
        end else begin
          step_q <= step_q + LW'(1);
        end
      end
      if (red_last && !uph_q) begin
        iss_q  <= '0;
        fill_q <= '0;
        if (row_last) begin
          uph_q <= 1'b1;
        end else begin
          row_q  <= row_q + RW'(1);
          base_q <= base_q + AW'(n_q);
        end
      end
    end
  end

  // working line: loads fill from the front, reduce shifts left and appends
  always_ff @(posedge clk_i) begin
    if (state_q == bspe_pkg::S_LOAD && rdv_q) begin
      for (int i = 0; i < LINE; i++) begin
        if (LW'(i) == fill_q) line_q[i] <= uph_q ? rm_rdata_q : st_rdata_q;
      end
    end else if (state_q == bspe_pkg::S_RED && len_q != LW'(1)) begin
      for (int i = 0; i < LINE - 1; i++) begin
        line_q[i] <= line_q[i+1];
      end
      if (step_q != len_q - LW'(1)) begin
        for (int i = 0; i < LINE; i++) begin
          if (LW'(i) == len_q - LW'(1)) line_q[i] <= lerp_r;
        end
      end
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == bspe_pkg::S_DONE && out_free) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == bspe_pkg::S_DONE && out_free) out_q <= line_q[0];
  end

  assign out_o.valid  = out_valid_q;
  assign out_o.surf_x = out_q[0 +: COORD_BITS];
  assign out_o.surf_y = out_q[COORD_BITS +: COORD_BITS];
  assign out_o.surf_z = out_q[2*COORD_BITS +: COORD_BITS];

  // an evaluate beat always starts with a load
  a_eval_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    eval_acc |=> state_q == bspe_pkg::S_LOAD)
    else $error("evaluate beat did not start a load");

  // reduction level never empty nor longer than the line
  a_len_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == bspe_pkg::S_RED |-> (len_q != '0) && (int'(len_q) <= LINE))
    else $error("reduction level out of range");

  // load never fills past the requested count
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == bspe_pkg::S_LOAD |-> fill_q < cnt)
    else $error("load overran count");

  // a finished result only moves to the output register when it is free
  a_done_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == bspe_pkg::S_DONE && out_valid_q && !out_o.ready)
      |=> state_q == bspe_pkg::S_DONE)
    else $error("result left while output occupied");

endmodule

/* tb/bezier_surface_point_eval_top_tb.sv */
// bezier_surface_point_eval_top_tb: self-checking bench for the bezier surface evaluator
// drives write/evaluate beats against a local de casteljau predictor
// depends on bspe_pkg, bspe_in_if, bspe_out_if and the rtl top level
module bezier_surface_point_eval_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned ROW_MAX   = 8;
  localparam int unsigned CROWS_MAX = 8;
  localparam int unsigned CB        = 32;
  localparam int unsigned PF        = 16;
  localparam longint      T_ONE     = 64'sd1 << PF;
  localparam int unsigned CYC_LIMIT = 2000000;
  localparam int unsigned RAND_PER_PHASE = 135;
  localparam int unsigned N_PHASES  = 8;
  localparam int unsigned SETTLE    = 16;

  typedef logic signed [CB-1:0] coord_t;
  typedef logic [PF:0]          param_t;

  typedef struct {
    logic   func;
    logic [5:0] idx;
    coord_t x, y, z;
    param_t u, v;
    bit     has_exp;
    coord_t ex, ey, ez;
  } beat_t;

  typedef struct {
    coord_t x, y, z;
  } point_t;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [bspe_pkg::CFG_IDX_W-1:0] cfg_idx_i;
  logic [bspe_pkg::CFG_W-1:0]     cfg_data_i;

  bspe_in_if  #(.COORD_BITS(CB), .PARAM_FRAC_BITS(PF)) in_bus ();
  bspe_out_if #(.COORD_BITS(CB)) out_bus ();

  bezier_surface_point_eval_top #(
    .MAX_ROW_LEN(ROW_MAX), .MAX_ROWS(CROWS_MAX), .COORD_BITS(CB), .PARAM_FRAC_BITS(PF)
  ) dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i),
    .cfg_data_i(cfg_data_i), .in_i(in_bus), .out_o(out_bus)
  );

  // predictor state: control points, which ones hold data, and the two dims
  coord_t     pts_x [64];
  coord_t     pts_y [64];
  coord_t     pts_z [64];
  bit         pt_known [64];
  logic [3:0] cur_len;
  logic [3:0] cur_rows;

  point_t surf_pending [$];   // surface points awaiting their result beat
  int     n_bad;
  bit     quiet;             // no idling on either side while set
  int unsigned cycles;
  beat_t  directed [24];

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYC_LIMIT) begin
      $display("[bezier_surface_point_eval_top] ERROR");
      $finish;
    end
  end

  function automatic int unsigned eff_dim(logic [3:0] r, int unsigned mx);
    if (r == 0) return 1;
    if (r > mx) return mx;
    return r;
  endfunction

  function automatic longint eff_param(param_t p);
    return (longint'(p) > T_ONE) ? 0 : longint'(p);
  endfunction

  // p*(1-t) + q*t, floored to the coordinate grid
  function automatic longint blend(longint p, longint q, longint t);
    return p + (((q - p) * t) >>> PF);
  endfunction

  // every store entry an evaluation under the current dims would read
  function automatic bit first_missing(output int unsigned hole);
    int unsigned n, m;
    n = eff_dim(cur_len, ROW_MAX);
    m = eff_dim(cur_rows, CROWS_MAX);
    for (int unsigned i = 0; i < m; i++)
      for (int unsigned j = 0; j < n; j++)
        if (!pt_known[(j + i * n) & 63]) begin
          hole = (j + i * n) & 63;
          return 1'b1;
        end
    return 1'b0;
  endfunction

  // tensor-product de casteljau: rows reduced at v, row results at u
  function automatic point_t surface_at(param_t up, param_t vp);
    int unsigned n, m, a;
    longint u, v;
    longint wx [8], wy [8], wz [8];
    longint rx [8], ry [8], rz [8];
    point_t r;
    n = eff_dim(cur_len, ROW_MAX);
    m = eff_dim(cur_rows, CROWS_MAX);
    u = eff_param(up);
    v = eff_param(vp);
    for (int unsigned i = 0; i < m; i++) begin
      for (int unsigned j = 0; j < n; j++) begin
        a = (j + i * n) & 63;
        wx[j] = pts_x[a];
        wy[j] = pts_y[a];
        wz[j] = pts_z[a];
      end
      for (int unsigned l = 1; l < n; l++)
        for (int unsigned j = 0; j + l < n; j++) begin
          wx[j] = blend(wx[j], wx[j+1], v);
          wy[j] = blend(wy[j], wy[j+1], v);
          wz[j] = blend(wz[j], wz[j+1], v);
        end
      rx[i] = wx[0];
      ry[i] = wy[0];
      rz[i] = wz[0];
    end
    for (int unsigned l = 1; l < m; l++)
      for (int unsigned i = 0; i + l < m; i++) begin
        rx[i] = blend(rx[i], rx[i+1], u);
        ry[i] = blend(ry[i], ry[i+1], u);
        rz[i] = blend(rz[i], rz[i+1], u);
      end
    r.x = coord_t'(rx[0]);
    r.y = coord_t'(ry[0]);
    r.z = coord_t'(rz[0]);
    return r;
  endfunction

  function automatic coord_t any_coord();
    case ($urandom_range(0, 7))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return '0;
      default: return coord_t'($urandom);
    endcase
  endfunction

  function automatic param_t any_param();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return param_t'(T_ONE);
      2: return param_t'($urandom_range(65537, 131071));   // above one, reads as zero
      default: return param_t'($urandom_range(0, 65536));
    endcase
  endfunction

  function automatic int unsigned gap_draw();
    return quiet ? 0 : $urandom_range(0, 17);
  endfunction

  // update the predictor with an accepted beat, queue its surface point if any
  task automatic take_beat(beat_t b);
    point_t p;
    if (b.func == bspe_pkg::FUNC_WRITE) begin
      pts_x[b.idx] = b.x;
      pts_y[b.idx] = b.y;
      pts_z[b.idx] = b.z;
      pt_known[b.idx] = 1'b1;
    end else begin
      p = surface_at(b.u, b.v);
      if (b.has_exp) begin
        p.x = b.ex;
        p.y = b.ey;
        p.z = b.ez;
      end
      surf_pending = {surf_pending, p};
    end
  endtask

  // one beat on the input channel; valid is left high for a back-to-back beat
  task automatic send_beat(beat_t b);
    int unsigned g;
    g = gap_draw();
    if (g > 0) begin
      in_bus.valid <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
    in_bus.valid       <= 1'b1;
    in_bus.func        <= b.func;
    in_bus.point_index <= b.idx;
    in_bus.coord_x     <= b.x;
    in_bus.coord_y     <= b.y;
    in_bus.coord_z     <= b.z;
    in_bus.u_param     <= b.u;
    in_bus.v_param     <= b.v;
    do @(posedge clk_i); while (!(in_bus.valid && in_bus.ready));
    take_beat(b);
  endtask

  // drain, let a trailing write settle, then change the dims
  task automatic set_dims(logic [3:0] len, logic [3:0] rows);
    in_bus.valid <= 1'b0;
    while (surf_pending.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= bspe_pkg::REG_ROW_LENGTH;
    cfg_data_i <= len;
    @(posedge clk_i);
    cfg_idx_i  <= bspe_pkg::REG_ROW_COUNT;
    cfg_data_i <= rows;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    cur_len  = len;
    cur_rows = rows;
  endtask

  // result side: random stalls, then compare against the oldest pending point
  initial begin
    int unsigned s;
    point_t e;
    out_bus.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      s = gap_draw();
      if (s > 0) begin
        out_bus.ready <= 1'b0;
        repeat (s) @(posedge clk_i);
      end
      out_bus.ready <= 1'b1;
      do @(posedge clk_i); while (!(out_bus.valid && out_bus.ready));
      if (surf_pending.size() == 0) begin
        n_bad++;
        if (n_bad <= 10)
          $display("unexpected result beat x=%h y=%h z=%h",
                   out_bus.surf_x, out_bus.surf_y, out_bus.surf_z);
      end else begin
        e = surf_pending.pop_front();
        if (out_bus.surf_x !== e.x || out_bus.surf_y !== e.y || out_bus.surf_z !== e.z)
        begin
          n_bad++;
          if (n_bad <= 10)
            $display("surface mismatch: expected %h %h %h, got %h %h %h",
                     e.x, e.y, e.z, out_bus.surf_x, out_bus.surf_y, out_bus.surf_z);
        end
      end
    end
  end

  initial begin
    beat_t b;
    int unsigned hole;
    logic [3:0] dims_len [N_PHASES];
    logic [3:0] dims_rows [N_PHASES];
    dims_len  = '{4'd8, 4'd0, 4'd15, 4'd1, 4'd8, 4'd3, 4'd2, 4'd7};
    dims_rows = '{4'd8, 4'd0, 4'd15, 4'd8, 4'd1, 4'd5, 4'd15, 4'd2};
    cycles = 0;
    n_bad  = 0;
    quiet  = 1'b0;
    cur_len  = bspe_pkg::ROW_LENGTH_RST;
    cur_rows = bspe_pkg::ROW_COUNT_RST;
    for (int i = 0; i < 64; i++) pt_known[i] = 1'b0;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = bspe_pkg::REG_ROW_LENGTH;
    cfg_data_i = '0;
    in_bus.valid = 1'b0;
    in_bus.func = bspe_pkg::FUNC_WRITE;
    in_bus.point_index = '0;
    in_bus.coord_x = '0;
    in_bus.coord_y = '0;
    in_bus.coord_z = '0;
    in_bus.u_param = '0;
    in_bus.v_param = '0;

    // directed: a flat 4x4 patch at the coordinate extremes evaluates to itself
    // for any parameter, including parameters above one
    for (int i = 0; i < 16; i++) begin
      directed[i] = '{bspe_pkg::FUNC_WRITE, 6'(i), 32'sh7fffffff, 32'sh80000000, '0,
                      (i % 2) ? 17'h1ffff : '0, (i % 2) ? '0 : 17'h1ffff, 1'b0, '0, '0, '0};
    end
    directed[16] = '{bspe_pkg::FUNC_EVAL, 6'h3f, 32'sh1, 32'sh1, 32'sh1, 17'd0, 17'd0, 1'b1,
                     32'sh7fffffff, 32'sh80000000, '0};
    directed[17] = '{bspe_pkg::FUNC_EVAL, 6'h00, '0, '0, '0, 17'd65536, 17'd65536, 1'b1,
                     32'sh7fffffff, 32'sh80000000, '0};
    directed[18] = '{bspe_pkg::FUNC_EVAL, 6'h15, '0, '0, '0, 17'd65537, 17'd1, 1'b1,
                     32'sh7fffffff, 32'sh80000000, '0};
    directed[19] = '{bspe_pkg::FUNC_EVAL, 6'h2a, '0, '0, '0, 17'h1ffff, 17'h1ffff, 1'b1,
                     32'sh7fffffff, 32'sh80000000, '0};
    directed[20] = '{bspe_pkg::FUNC_EVAL, 6'h00, '0, '0, '0, 17'd32768, 17'd12345, 1'b1,
                     32'sh7fffffff, 32'sh80000000, '0};
    // one corner moved: that corner and an inner point go through the predictor
    directed[21] = '{bspe_pkg::FUNC_WRITE, 6'd0, -32'sd1, 32'sd1, 32'sh12345678, '0, '0,
                     1'b0, '0, '0, '0};
    directed[22] = '{bspe_pkg::FUNC_EVAL, 6'd0, '0, '0, '0, 17'd0, 17'd0, 1'b0,
                     '0, '0, '0};
    directed[23] = '{bspe_pkg::FUNC_EVAL, 6'd0, '0, '0, '0, 17'd21845, 17'd40000, 1'b0,
                     '0, '0, '0};

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed[i]) send_beat(directed[i]);

    for (int ph = 0; ph < N_PHASES; ph++) begin
      set_dims(dims_len[ph], dims_rows[ph]);
      quiet = ($urandom_range(0, 3) == 0);
      for (int k = 0; k < RAND_PER_PHASE; k++) begin
        b.idx = 6'($urandom);
        b.x = any_coord();
        b.y = any_coord();
        b.z = any_coord();
        b.u = any_param();
        b.v = any_param();
        b.has_exp = 1'b0;
        b.ex = '0;
        b.ey = '0;
        b.ez = '0;
        b.func = ($urandom_range(0, 99) < 45) ? bspe_pkg::FUNC_EVAL : bspe_pkg::FUNC_WRITE;
        // never evaluate over a hole in the store: fill it instead
        if (b.func == bspe_pkg::FUNC_EVAL && first_missing(hole)) begin
          b.func = bspe_pkg::FUNC_WRITE;
          b.idx  = 6'(hole);
        end
        send_beat(b);
      end
    end

    in_bus.valid <= 1'b0;
    while (surf_pending.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
    if (n_bad == 0) begin
      $display("[bezier_surface_point_eval_top] OK");
    end else begin
      $display("[bezier_surface_point_eval_top] ERROR");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/bspe_pkg.sv
rtl/bspe_in_if.sv
rtl/bspe_out_if.sv
rtl/bspe_lerp3.sv
rtl/bezier_surface_point_eval_top.sv
tb/bezier_surface_point_eval_top_tb.sv
